FILE: hdl/hmd_pkg.sv
// ----------------------------------------------------------------------------
// hmd_pkg: shared types and constants
// Codeword geometry, queue entry layout and default sizing for the
// Hamming (15,11) stream decoder.
// ----------------------------------------------------------------------------
package hmd_pkg;

	localparam int CW_LEN              = 15;
	localparam int DATA_LEN            = 11;
	localparam int DEFAULT_QUEUE_DEPTH = 2;

	// One decoded codeword's worth of output: one or two bytes.
	typedef struct packed {
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [31:0] corrections;
		logic        two;
	} entry_t;

endpackage

FILE: hdl/hmd_rx_if.sv
// ----------------------------------------------------------------------------
// hmd_rx_if: coded byte channel
// Valid/ready channel carrying received bytes and the end-of-packet mark.
// ----------------------------------------------------------------------------
interface hmd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       packet_end;

	modport source (output valid, output rx_byte, output packet_end, input ready);
	modport sink (input valid, input rx_byte, input packet_end, output ready);
endinterface

FILE: hdl/hmd_tx_if.sv
// ----------------------------------------------------------------------------
// hmd_tx_if: decoded byte channel
// Valid/ready channel carrying decoded bytes and the correction count.
// ----------------------------------------------------------------------------
interface hmd_tx_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [31:0] corrections;
	logic        last_of_run;

	modport source (output valid, output data_byte, output corrections,
		output last_of_run, input ready);
	modport sink (input valid, input data_byte, input corrections,
		input last_of_run, output ready);
endinterface

FILE: hdl/hmd_front.sv
// ----------------------------------------------------------------------------
// hmd_front: codeword gather, correct and pack
// Accepts one coded byte per cycle unless full is set, completes codewords,
// corrects single errors, packs data bits, pushes finished bytes to the queue.
// ----------------------------------------------------------------------------
module hmd_front (
	input  logic            clk,
	input  logic            arst_n,
	hmd_rx_if.sink          rx,
	input  logic            full,
	output logic            push,
	output hmd_pkg::entry_t push_entry
);

	logic [14:0] cw_q;
	logic [3:0]  fill_q;
	logic [6:0]  oacc_q;
	logic [2:0]  ofill_q;
	logic [31:0] cnt_q;

	logic        accept;
	logic        complete;
	logic [2:0]  sh;
	logic [21:0] cat;
	logic [14:0] cw;
	logic [14:0] cwc;
	logic [3:0]  syn;
	logic [10:0] data;
	logic [17:0] comb;
	logic        two;
	logic [2:0]  rfill;
	logic [6:0]  racc;
	logic [31:0] cnt_next;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign complete = fill_q >= 4'd7;
	assign sh       = 3'(fill_q - 4'd7);
	assign cat      = {cw_q[13:0], rx.rx_byte};
	assign cw       = 15'(cat >> sh);

	always_comb begin
		syn = '0;
		for (int p = 1; p <= hmd_pkg::CW_LEN; p++) begin
			if (cw[hmd_pkg::CW_LEN - p]) begin
				syn = syn ^ 4'(p);
			end
		end
	end

	always_comb begin
		cwc = cw;
		if (syn != 4'd0) begin
			cwc = cw ^ (15'd1 << (4'd15 - syn));
		end
	end

	assign data     = {cwc[12], cwc[10:8], cwc[6:0]};
	assign comb     = {oacc_q, data};
	assign two      = ofill_q >= 3'd5;
	assign rfill    = two ? 3'(ofill_q - 3'd5) : 3'(ofill_q + 3'd3);
	assign racc     = 7'(comb) & 7'((8'd1 << rfill) - 8'd1);
	assign cnt_next = (syn != 4'd0 && cnt_q != '1) ? cnt_q + 32'd1 : cnt_q;

	assign push                   = accept && complete;
	assign push_entry.byte0       = 8'(comb >> (5'(ofill_q) + 5'd3));
	assign push_entry.byte1       = 8'(comb >> rfill);
	assign push_entry.corrections = cnt_next;
	assign push_entry.two         = two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q    <= '0;
			fill_q  <= '0;
			oacc_q  <= '0;
			ofill_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (complete) begin
				cnt_q <= cnt_next;
			end
			if (rx.packet_end) begin
				cw_q    <= '0;
				fill_q  <= '0;
				oacc_q  <= '0;
				ofill_q <= '0;
			end else if (complete) begin
				cw_q    <= {7'd0, rx.rx_byte & 8'((9'd1 << sh) - 9'd1)};
				fill_q  <= 4'(sh);
				oacc_q  <= racc;
				ofill_q <= rfill;
			end else begin
				cw_q   <= {cw_q[6:0], rx.rx_byte};
				fill_q <= fill_q + 4'd8;
			end
		end
	end

endmodule

FILE: hdl/hmd_queue.sv
// ----------------------------------------------------------------------------
// hmd_queue: entry queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module hmd_queue #(
	parameter int Depth = hmd_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hmd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hmd_pkg::entry_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	hmd_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full       = cnt_q == CntW'(Depth);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

FILE: hdl/hmd_back.sv
// ----------------------------------------------------------------------------
// hmd_back: result emitter
// Splits each queue entry into one or two items and drives the output
// register.
// ----------------------------------------------------------------------------
module hmd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  hmd_pkg::entry_t head,
	output logic            pop,
	hmd_tx_if.source        tx
);

	logic        valid_q;
	logic [7:0]  byte_q;
	logic [31:0] corr_q;
	logic        last_q;
	logic        sel_q;
	logic        load;
	logic        is_last;

	assign load    = head_valid && (!valid_q || tx.ready);
	assign is_last = sel_q || !head.two;
	assign pop     = load && is_last;

	assign tx.valid       = valid_q;
	assign tx.data_byte   = byte_q;
	assign tx.corrections = corr_q;
	assign tx.last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !is_last;
			end else if (tx.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_q ? head.byte1 : head.byte0;
			corr_q <= head.corrections;
			last_q <= is_last;
		end
	end

endmodule

FILE: hdl/hamming_15_11_stream_decoder.sv
// ----------------------------------------------------------------------------
// hamming_15_11_stream_decoder: Hamming (15,11) stream decoder
// Gathers coded bytes into codewords, corrects single-bit errors and emits
// the packed data bytes with a running correction count.
// ----------------------------------------------------------------------------
// The rx side takes one byte per cycle whenever the entry queue has room.
// A byte that completes a codeword yields one or two output items, which
// leave through the registered tx side at one item per cycle while tx is
// ready. Two bytes in a row complete codewords only when the second
// codeword ends exactly on a byte boundary; if the first of that pair
// yields two items the queue fills and rx stalls. With tx always ready a
// stream (about 0.73 items per byte) therefore runs at one byte per cycle
// apart from such stalls. On packet_end the partial codeword and partial
// output byte are dropped; the correction count is kept and saturates at
// all ones.
module hamming_15_11_stream_decoder #(
	parameter int QueueDepth = hmd_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	hmd_rx_if.sink   rx,
	hmd_tx_if.source tx
);

	hmd_pkg::entry_t push_entry;
	hmd_pkg::entry_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            head_valid;

	hmd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	hmd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

FILE: bench/hamming_15_11_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_15_11_stream_decoder_tb: self-checking bench for the stream decoder
// Drives a short table of directed coded bytes, then random packets of
// encoded codewords with zero, one or two bit errors plus raw noise. Every
// decoded item is checked field by field against the table or a behavioral
// decoder, under random idle gaps on rx and random stalls on the tx side.
// ----------------------------------------------------------------------------
module hamming_15_11_stream_decoder_tb;

	localparam int CwLen       = hmd_pkg::CW_LEN;
	localparam int RandomItems = 1750;
	localparam int Predicted   = -1;
	localparam int DirRows     = 24;

	typedef struct {
		logic [7:0]  rx;
		logic        eop;
		int          n_exp;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [31:0] fixes;
	} row_t;

	typedef struct {
		logic [7:0]  data;
		logic [31:0] fixes;
		logic        last;
	} dec_item_t;

	logic clk;
	logic arst_n;

	hmd_rx_if rx_ch ();
	hmd_tx_if tx_ch ();

	hamming_15_11_stream_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	// rx, eop, results, byte0, byte1, corrections
	row_t dir_tab [DirRows] = '{
		'{8'h00, 1'b0, 0,         8'h00, 8'h00, 32'd0},
		'{8'h00, 1'b1, 1,         8'h00, 8'h00, 32'd0},
		'{8'hFF, 1'b0, 0,         8'h00, 8'h00, 32'd0},
		'{8'hFF, 1'b1, 1,         8'hFF, 8'h00, 32'd0},
		'{8'h80, 1'b0, 0,         8'h00, 8'h00, 32'd0},
		'{8'h00, 1'b1, 1,         8'h00, 8'h00, 32'd1},
		'{8'h00, 1'b0, 0,         8'h00, 8'h00, 32'd1},
		'{8'h02, 1'b1, 1,         8'h00, 8'h00, 32'd2},
		'{8'h20, 1'b0, 0,         8'h00, 8'h00, 32'd2},
		'{8'h00, 1'b1, 1,         8'h00, 8'h00, 32'd3},
		'{8'hC0, 1'b0, Predicted, 8'h00, 8'h00, 32'd0},
		'{8'h00, 1'b1, Predicted, 8'h00, 8'h00, 32'd0},
		'{8'hFF, 1'b0, 0,         8'h00, 8'h00, 32'd4},
		'{8'hFF, 1'b0, 1,         8'hFF, 8'h00, 32'd4},
		'{8'hFF, 1'b0, 0,         8'h00, 8'h00, 32'd4},
		'{8'hFF, 1'b0, 1,         8'hFF, 8'h00, 32'd4},
		'{8'hFF, 1'b0, 0,         8'h00, 8'h00, 32'd4},
		'{8'hFF, 1'b1, 2,         8'hFF, 8'hFF, 32'd4},
		'{8'hFF, 1'b1, 0,         8'h00, 8'h00, 32'd4},
		'{8'h00, 1'b0, 0,         8'h00, 8'h00, 32'd4},
		'{8'h00, 1'b1, 1,         8'h00, 8'h00, 32'd4},
		'{8'hA5, 1'b0, Predicted, 8'h00, 8'h00, 32'd0},
		'{8'h5A, 1'b0, Predicted, 8'h00, 8'h00, 32'd0},
		'{8'h3C, 1'b1, Predicted, 8'h00, 8'h00, 32'd0}
	};

	// decoder state mirror
	logic [14:0] cw_reg    = '0;
	int          cw_cnt    = 0;
	logic [7:0]  acc       = '0;
	int          acc_cnt   = 0;
	logic [31:0] fix_count = '0;
	dec_item_t   step_out [2];
	int          step_n;

	dec_item_t decoded_q [$];
	row_t      pending_rows [$];
	row_t      row_now;
	dec_item_t want;

	int src_calm       = 0;
	int sink_calm      = 0;
	int mismatch_total = 0;
	int n_sent         = 0;
	int n_eop          = 0;
	int n_checked      = 0;

	function automatic void emit_bit(input logic bt);
		acc = {acc[6:0], bt};
		acc_cnt++;
		if (acc_cnt == 8) begin
			step_out[step_n] = '{acc, fix_count, 1'b0};
			step_n++;
			acc = '0;
			acc_cnt = 0;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eop);
		logic [3:0]  syn;
		logic [14:0] word;
		step_n = 0;
		for (int i = 7; i >= 0; i--) begin
			cw_reg = {cw_reg[13:0], b[i]};
			cw_cnt++;
			if (cw_cnt == CwLen) begin
				syn = '0;
				for (int p = 1; p <= CwLen; p++)
					if (cw_reg[CwLen - p])
						syn = syn ^ 4'(p);
				word = cw_reg;
				if (syn != 4'd0) begin
					word[CwLen - syn] = ~word[CwLen - syn];
					if (fix_count != '1)
						fix_count++;
				end
				// data bits sit at every position that is not a power of two
				for (int p = 1; p <= CwLen; p++)
					if ((p & (p - 1)) != 0)
						emit_bit(word[CwLen - p]);
				cw_reg = '0;
				cw_cnt = 0;
			end
		end
		if (step_n > 0)
			step_out[step_n - 1].last = 1'b1;
		if (eop) begin
			cw_reg = '0;
			cw_cnt = 0;
			acc = '0;
			acc_cnt = 0;
		end
	endfunction

	function automatic logic [14:0] encode_word(input logic [10:0] d);
		logic [14:0] word;
		logic        par;
		int          k;
		word = '0;
		k = 10;
		for (int p = 1; p <= CwLen; p++)
			if ((p & (p - 1)) != 0) begin
				word[CwLen - p] = d[k];
				k--;
			end
		for (int j = 0; j < 4; j++) begin
			par = 1'b0;
			for (int p = 1; p <= CwLen; p++)
				if (((p >> j) & 1) != 0)
					par = par ^ word[CwLen - p];
			word[CwLen - (1 << j)] = par;
		end
		return word;
	endfunction

	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic row_t free_row(input logic [7:0] b, input logic e);
		row_t r;
		r = '{b, e, Predicted, 8'h00, 8'h00, 32'd0};
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_total++;
		if (mismatch_total <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input row_t r);
		int gap;
		gap = pick_wait(src_calm);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid      <= 1'b1;
		rx_ch.rx_byte    <= r.rx;
		rx_ch.packet_end <= r.eop;
		pending_rows.push_back(r);
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic send_packet();
		bit          pkt [$];
		int          ncw;
		int          nbytes;
		logic [14:0] word;
		logic [7:0]  b;
		bit          close;
		ncw = $urandom_range(1, 6);
		for (int k = 0; k < ncw; k++) begin
			word = encode_word(11'($urandom));
			case ($urandom_range(0, 9))
				6, 7, 8: begin
					word[$urandom_range(0, 14)] ^= 1'b1;
				end
				9: begin
					word[$urandom_range(0, 14)] ^= 1'b1;
					word[$urandom_range(0, 14)] ^= 1'b1;
				end
				default: begin
				end
			endcase
			for (int p = 14; p >= 0; p--)
				pkt.push_back(word[p]);
		end
		repeat ($urandom_range(0, 14)) pkt.push_back(1'($urandom));
		while (pkt.size() % 8 != 0)
			pkt.push_back(1'($urandom));
		nbytes = pkt.size() / 8;
		close = ($urandom_range(0, 9) != 0);
		for (int j = 0; j < nbytes; j++) begin
			b = '0;
			for (int k = 0; k < 8; k++)
				b = {b[6:0], pkt[8 * j + k]};
			send_item(free_row(b, close && (j == nbytes - 1)));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("hamming_15_11_stream_decoder_tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				row_now = pending_rows.pop_front();
				decode_byte(rx_ch.rx_byte, rx_ch.packet_end);
				if (rx_ch.packet_end)
					n_eop++;
				if (row_now.n_exp >= 0) begin
					for (int i = 0; i < row_now.n_exp; i++)
						decoded_q.push_back('{(i == 0) ? row_now.b0 : row_now.b1,
							row_now.fixes, i == row_now.n_exp - 1});
				end else begin
					for (int i = 0; i < step_n; i++)
						decoded_q.push_back(step_out[i]);
				end
			end
			if (tx_ch.valid && tx_ch.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item data_byte=%02h corrections=%0d",
						tx_ch.data_byte, tx_ch.corrections));
				end else begin
					want = decoded_q.pop_front();
					n_checked++;
					if (tx_ch.data_byte !== want.data)
						report_mismatch($sformatf("data_byte %02h, want %02h",
							tx_ch.data_byte, want.data));
					if (tx_ch.corrections !== want.fixes)
						report_mismatch($sformatf("corrections %0d, want %0d",
							tx_ch.corrections, want.fixes));
					if (tx_ch.last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %b, want %b",
							tx_ch.last_of_run, want.last));
				end
			end
		end
	end

	initial begin
		int stall;
		tx_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = pick_wait(sink_calm);
			if (stall > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tx_ch.ready <= 1'b1;
			do @(posedge clk); while (!tx_ch.valid);
		end
	end

	initial begin
		arst_n           = 1'b0;
		rx_ch.valid      = 1'b0;
		rx_ch.rx_byte    = 8'h00;
		rx_ch.packet_end = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DirRows; r++)
			send_item(dir_tab[r]);

		while (n_sent < DirRows + RandomItems) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 8))
					send_item(free_row(8'($urandom), $urandom_range(0, 3) == 0));
			end else begin
				send_packet();
			end
		end
		rx_ch.valid <= 1'b0;

		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("sent %0d coded bytes with %0d packet ends; checked %0d decoded items",
			n_sent, n_eop, n_checked);
		$display("corrected codewords seen: %0d", fix_count);
		if (mismatch_total == 0)
			$display("hamming_15_11_stream_decoder_tb: clean");
		else
			$display("hamming_15_11_stream_decoder_tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/hmd_pkg.sv
hdl/hmd_rx_if.sv
hdl/hmd_tx_if.sv
hdl/hmd_front.sv
hdl/hmd_queue.sv
hdl/hmd_back.sv
hdl/hamming_15_11_stream_decoder.sv
bench/hamming_15_11_stream_decoder_tb.sv
